>>> hdl/scfb_pkg.sv
package scfb_pkg;

  // command kinds
  localparam logic [1:0] FUNC_SET_ID = 2'd0;
  localparam logic [1:0] FUNC_MOVE   = 2'd1;
  localparam logic [1:0] FUNC_UNLOAD = 2'd2;
  localparam logic [1:0] FUNC_LOAD   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_FRAME_HEADER    = 2'd0;
  localparam logic [1:0] REG_OPCODE_MOVE     = 2'd1;
  localparam logic [1:0] REG_OPCODE_ID_WRITE = 2'd2;
  localparam logic [1:0] REG_OPCODE_LOAD     = 2'd3;

  // register reset values
  localparam logic [7:0] RST_FRAME_HEADER    = 8'd85;
  localparam logic [7:0] RST_OPCODE_MOVE     = 8'd1;
  localparam logic [7:0] RST_OPCODE_ID_WRITE = 8'd13;
  localparam logic [7:0] RST_OPCODE_LOAD     = 8'd31;

  localparam int         FRAME_MAX = 10;
  localparam logic [9:0] POS_MAX   = 10'd1000;
  localparam logic [7:0] SHORT_LEN = 8'd4;
  localparam logic [7:0] MOVE_LEN  = 8'd7;
  localparam logic [7:0] PARAM_UNLOAD = 8'd0;
  localparam logic [7:0] PARAM_LOAD   = 8'd1;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         servo_id;
    logic [7:0]         new_id;
    logic signed [15:0] target_position;
    logic [15:0]        move_time;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_out_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } cell_t;

  typedef struct packed {
    logic [7:0] frame_header;
    logic [7:0] opcode_move;
    logic [7:0] opcode_id_write;
    logic [7:0] opcode_load;
  } cfg_regs_t;

endpackage

>>> hdl/scfb_cell.sv
module scfb_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_en,
  input  logic            shift_en,
  input  scfb_pkg::cell_t load_cell,
  input  scfb_pkg::cell_t up_cell,
  output scfb_pkg::cell_t cell_q
);

  logic       valid_r;
  logic       valid_nxt;
  logic       last_r;
  logic [7:0] data_r;

  always_comb begin
    if (load_en) begin
      valid_nxt = load_cell.valid;
    end else if (shift_en) begin
      valid_nxt = up_cell.valid;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload takes no reset
  always_ff @(posedge clk) begin
    if (load_en) begin
      last_r <= load_cell.last;
      data_r <= load_cell.data;
    end else if (shift_en) begin
      last_r <= up_cell.last;
      data_r <= up_cell.data;
    end
  end

  assign cell_q = '{valid: valid_r, last: last_r, data: data_r};

endmodule

>>> hdl/scfb_frame_fmt.sv
module scfb_frame_fmt (
  input  scfb_pkg::cmd_t                               cmd,
  input  scfb_pkg::cfg_regs_t                          regs,
  output scfb_pkg::cell_t [scfb_pkg::FRAME_MAX-1:0]    frame
);

  logic       is_move;
  logic [9:0] pos;
  logic [7:0] len;
  logic [7:0] opcode;
  logic [7:0] p0;
  logic [7:0] p1;
  logic [7:0] p2;
  logic [7:0] p3;
  logic [7:0] sum;
  logic [7:0] csum;

  assign is_move = (cmd.func == scfb_pkg::FUNC_MOVE);

  // clamp to 0..1000
  always_comb begin
    if (cmd.target_position[15]) begin
      pos = '0;
    end else if (cmd.target_position[14:0] > {5'd0, scfb_pkg::POS_MAX}) begin
      pos = scfb_pkg::POS_MAX;
    end else begin
      pos = cmd.target_position[9:0];
    end
  end

  always_comb begin
    len    = scfb_pkg::SHORT_LEN;
    opcode = regs.opcode_load;
    p0     = scfb_pkg::PARAM_UNLOAD;
    p1     = '0;
    p2     = '0;
    p3     = '0;
    case (cmd.func)
      scfb_pkg::FUNC_SET_ID: begin
        opcode = regs.opcode_id_write;
        p0     = cmd.new_id;
      end
      scfb_pkg::FUNC_MOVE: begin
        len    = scfb_pkg::MOVE_LEN;
        opcode = regs.opcode_move;
        p0     = pos[7:0];
        p1     = {6'd0, pos[9:8]};
        p2     = cmd.move_time[7:0];
        p3     = cmd.move_time[15:8];
      end
      scfb_pkg::FUNC_UNLOAD: begin
        p0 = scfb_pkg::PARAM_UNLOAD;
      end
      scfb_pkg::FUNC_LOAD: begin
        p0 = scfb_pkg::PARAM_LOAD;
      end
      default: begin
        p0 = scfb_pkg::PARAM_UNLOAD;
      end
    endcase
  end

  // unused parameter bytes are zero for short frames
  assign sum  = cmd.servo_id + len + opcode + p0 + p1 + p2 + p3;
  assign csum = ~sum;

  always_comb begin
    frame[0] = '{valid: 1'b1, last: 1'b0, data: regs.frame_header};
    frame[1] = '{valid: 1'b1, last: 1'b0, data: regs.frame_header};
    frame[2] = '{valid: 1'b1, last: 1'b0, data: cmd.servo_id};
    frame[3] = '{valid: 1'b1, last: 1'b0, data: len};
    frame[4] = '{valid: 1'b1, last: 1'b0, data: opcode};
    frame[5] = '{valid: 1'b1, last: 1'b0, data: p0};
    if (is_move) begin
      frame[6] = '{valid: 1'b1, last: 1'b0, data: p1};
      frame[7] = '{valid: 1'b1, last: 1'b0, data: p2};
      frame[8] = '{valid: 1'b1, last: 1'b0, data: p3};
      frame[9] = '{valid: 1'b1, last: 1'b1, data: csum};
    end else begin
      frame[6] = '{valid: 1'b1, last: 1'b1, data: csum};
      frame[7] = '{valid: 1'b0, last: 1'b0, data: '0};
      frame[8] = '{valid: 1'b0, last: 1'b0, data: '0};
      frame[9] = '{valid: 1'b0, last: 1'b0, data: '0};
    end
  end

endmodule

>>> hdl/servo_command_frame_builder_unit.sv
// channel   | direction | handshake              | payload
// in_       | request   | in_valid / in_ready    | scfb_pkg::cmd_t (one servo command)
// out_      | result    | out_valid / out_ready  | scfb_pkg::frame_out_t (one frame byte)
// cfg_      | register  | apb psel/penable       | 8-bit registers at byte addr 4*i
//
// a request loads its whole frame, 7 or 10 bytes, into a row of ten byte cells
// the row shifts one byte a cycle toward cell 0, the output register, unless the output stalls
// a request sends 7 frame bytes (set id, load, unload) or 10 (move) through
// the single output byte lane, one byte at a time
// the next request loads in the cycle the checksum byte is taken, no bubble
// rst_n is synchronous: it empties the row and restores register defaults
// an output stall freezes the whole row; in_ready stays low until it drains
module servo_command_frame_builder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  scfb_pkg::cmd_t        in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output scfb_pkg::frame_out_t  out_data,
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int N = scfb_pkg::FRAME_MAX;

  // configuration registers
  scfb_pkg::cfg_regs_t regs_r;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.frame_header    <= scfb_pkg::RST_FRAME_HEADER;
      regs_r.opcode_move     <= scfb_pkg::RST_OPCODE_MOVE;
      regs_r.opcode_id_write <= scfb_pkg::RST_OPCODE_ID_WRITE;
      regs_r.opcode_load     <= scfb_pkg::RST_OPCODE_LOAD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        scfb_pkg::REG_FRAME_HEADER:    regs_r.frame_header    <= cfg_pwdata[7:0];
        scfb_pkg::REG_OPCODE_MOVE:     regs_r.opcode_move     <= cfg_pwdata[7:0];
        scfb_pkg::REG_OPCODE_ID_WRITE: regs_r.opcode_id_write <= cfg_pwdata[7:0];
        scfb_pkg::REG_OPCODE_LOAD:     regs_r.opcode_load     <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      scfb_pkg::REG_FRAME_HEADER:    cfg_prdata = {24'd0, regs_r.frame_header};
      scfb_pkg::REG_OPCODE_MOVE:     cfg_prdata = {24'd0, regs_r.opcode_move};
      scfb_pkg::REG_OPCODE_ID_WRITE: cfg_prdata = {24'd0, regs_r.opcode_id_write};
      scfb_pkg::REG_OPCODE_LOAD:     cfg_prdata = {24'd0, regs_r.opcode_load};
      default:                       cfg_prdata = '0;
    endcase
  end

  // frame formatter: header, id, length, opcode, params, checksum
  scfb_pkg::cell_t [N-1:0] frame;

  scfb_frame_fmt u_fmt (
    .cmd   (in_data),
    .regs  (regs_r),
    .frame (frame)
  );

  // cell row; cell 0 drives the output
  scfb_pkg::cell_t [N-1:0] cell_q;
  scfb_pkg::cell_t [N-1:0] up_cell;
  logic [N-1:0]            cell_valid;
  logic                    shift_en;
  logic                    tail_empty;
  logic                    load_en;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_valid[i] = cell_q[i].valid;
    end
  end

  // output slot frees when empty or taken
  assign shift_en   = !cell_q[0].valid || out_ready;
  // only cell 0 may still hold a byte when the next frame loads
  assign tail_empty = (cell_valid[N-1:1] == '0);
  assign in_ready   = shift_en && tail_empty;
  assign load_en    = in_valid && in_ready;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_end
        assign up_cell[g] = '{valid: 1'b0, last: 1'b0, data: '0};
      end else begin : g_mid
        assign up_cell[g] = cell_q[g+1];
      end

      scfb_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .shift_en  (shift_en),
        .load_cell (frame[g]),
        .up_cell   (up_cell[g]),
        .cell_q    (cell_q[g])
      );
    end
  endgenerate

  assign out_valid           = cell_q[0].valid;
  assign out_data.frame_byte = cell_q[0].data;
  assign out_data.last_byte  = cell_q[0].last;

`ifndef SYNTHESIS
  // an accepted request shows its first header byte in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request did not reach the output cell");

  // the checksum byte is always the last one in the row
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_byte |-> !cell_q[1].valid)
    else $error("bytes queued behind the checksum byte");

  // occupied cells stay packed toward the output
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("gap in the cell row");

  // a non-last byte always has a successor queued
  a_frame_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_byte |-> cell_q[1].valid)
    else $error("frame cut short in the cell row");
`endif

endmodule
